@@ hdl/tafs_pkg.sv @@
package tafs_pkg;

  typedef enum logic [1:0] {
    MODE_LOOP     = 2'd0,
    MODE_ONCE     = 2'd1,
    MODE_PINGPONG = 2'd2,
    MODE_SPARE    = 2'd3
  } anim_mode_t;

  typedef enum logic [1:0] {
    REG_FRAME_COUNT    = 2'd0,
    REG_FRAME_DURATION = 2'd1,
    REG_ANIM_MODE      = 2'd2,
    REG_RANDOM_OFFSET  = 2'd3
  } cfg_reg_t;

  localparam logic [31:0] HASH_MUL_X = 32'd73856093;
  localparam logic [31:0] HASH_MUL_Y = 32'd19349663;
  localparam logic [31:0] HASH_MIX   = 32'h5bd1e995;

endpackage

@@ hdl/tile_animation_frame_select.sv @@
// Tile animation frame selector. Each input beat carries a time in ticks and a
// tile position; each output beat returns the selected animation frame and the
// 32-bit position hash. The block is a fully pipelined datapath that accepts one
// beat per clock and returns one beat per clock while the output is not stalled.
// It is built around two one-bit-per-stage restoring dividers: a 32-stage
// section that divides the time by the frame duration and, in parallel,
// reduces the hash modulo the frame count, followed by SW stages
// (SW = max(TIME_BITS, clog2(MAX_FRAMES+1)) + 1) that reduce the step modulo
// the animation period.
// A stall on the output freezes the whole pipeline; nothing is dropped or
// repeated. Configuration must only be written while the pipeline is empty.
module tile_animation_frame_select
  import tafs_pkg::*;
#(
  parameter int MAX_FRAMES = 256,
  parameter int TIME_BITS  = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [30:0] in_time_ticks,
  input  logic signed [15:0] in_tile_x,
  input  logic signed [15:0] in_tile_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_frame_index,
  output logic [31:0] out_position_hash,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // NB holds a saturated frame count, MB holds the animation period, n or 2(n-1).
  localparam int TB = TIME_BITS;
  localparam int NB = $clog2(MAX_FRAMES + 1);
  localparam int MB = NB + 1;
  localparam int SW = ((TB > NB) ? TB : NB) + 1;
  localparam int DS = 32;

  // Configuration registers.
  logic [8:0]  frame_count_r;
  logic [15:0] frame_duration_r;
  anim_mode_t  anim_mode_r;
  logic        random_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r    <= 9'd1;
      frame_duration_r <= 16'd1;
      anim_mode_r      <= MODE_LOOP;
      random_offset_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_COUNT:    frame_count_r    <= cfg_data[8:0];
        REG_FRAME_DURATION: frame_duration_r <= cfg_data;
        REG_ANIM_MODE:      anim_mode_r      <= anim_mode_t'(cfg_data[1:0]);
        REG_RANDOM_OFFSET:  random_offset_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Derived configuration: saturated count, period divisor, degenerate flag.
  logic [NB-1:0] n_sat;
  logic [NB-1:0] n_m1;
  logic [MB-1:0] period;
  logic          degenerate;

  always_comb begin
    if (32'(frame_count_r) > 32'(MAX_FRAMES)) begin
      n_sat = NB'(MAX_FRAMES);
    end else begin
      n_sat = NB'(32'(frame_count_r));
    end
    n_m1 = n_sat - NB'(1);
    if (anim_mode_r == MODE_PINGPONG) begin
      period = {n_m1, 1'b0};
    end else begin
      period = {1'b0, n_sat};
    end
    degenerate = (32'(n_sat) <= 32'd1) || (frame_duration_r == 16'd0);
  end

  // The whole pipeline advances together unless the output holds a beat
  // that the consumer is not taking.
  logic out_valid_r;
  logic adv;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Hash stages.
  logic          h0_v_r, h1_v_r;
  logic [31:0]   h0_xm_r, h0_ym_r, h1_m_r;
  logic [TB-1:0] h0_t_r, h1_t_r;
  logic [31:0]   hx_mix;

  assign hx_mix = (h0_xm_r ^ h0_ym_r) ^ ((h0_xm_r ^ h0_ym_r) >> 13);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h0_v_r <= 1'b0;
      h1_v_r <= 1'b0;
    end else if (adv) begin
      h0_v_r <= in_valid;
      h1_v_r <= h0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h0_xm_r <= 32'(32'(in_tile_x) * HASH_MUL_X);
      h0_ym_r <= 32'(32'(in_tile_y) * HASH_MUL_Y);
      h0_t_r  <= in_time_ticks[TB-1:0];
      h1_m_r  <= 32'(hx_mix * HASH_MIX);
      h1_t_r  <= h0_t_r;
    end
  end

  // Divider section: time / duration and hash mod count, one bit a stage.
  logic          dv_r   [0:DS];
  logic [31:0]   dh_r   [0:DS];
  logic [31:0]   dhs_r  [0:DS];
  logic [NB-1:0] dhr_r  [0:DS];
  logic [TB-1:0] dt_r   [0:DS];
  logic [15:0]   dtr_r  [0:DS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= h1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dh_r[0]  <= h1_m_r ^ (h1_m_r >> 15);
      dhs_r[0] <= h1_m_r ^ (h1_m_r >> 15);
      dhr_r[0] <= '0;
      dt_r[0]  <= h1_t_r;
      dtr_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < DS; i++) begin : g_div
    logic [NB:0] hsh;
    logic [NB:0] hsub;

    assign hsh  = {dhr_r[i], dhs_r[i][31]};
    assign hsub = hsh - {1'b0, n_sat};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[i+1] <= 1'b0;
      end else if (adv) begin
        dv_r[i+1] <= dv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dh_r[i+1]  <= dh_r[i];
        dhs_r[i+1] <= dhs_r[i] << 1;
        dhr_r[i+1] <= (hsh >= {1'b0, n_sat}) ? hsub[NB-1:0] : hsh[NB-1:0];
      end
    end

    if (i >= DS - TB) begin : g_tdiv
      logic [16:0] tsh;
      logic [16:0] tsub;
      logic        ge;

      assign tsh  = {dtr_r[i], dt_r[i][TB-1]};
      assign tsub = tsh - {1'b0, frame_duration_r};
      assign ge   = tsh >= {1'b0, frame_duration_r};

      always_ff @(posedge clk) begin
        if (adv) begin
          dtr_r[i+1] <= ge ? tsub[15:0] : tsh[15:0];
          dt_r[i+1]  <= {dt_r[i][TB-2:0], ge};
        end
      end
    end else begin : g_tpass
      always_ff @(posedge clk) begin
        if (adv) begin
          dtr_r[i+1] <= dtr_r[i];
          dt_r[i+1]  <= dt_r[i];
        end
      end
    end
  end

  // Step stage and step mod period section.
  logic          mv_r  [0:SW];
  logic [31:0]   mh_r  [0:SW];
  logic [SW-1:0] mst_r [0:SW];
  logic [SW-1:0] msh_r [0:SW];
  logic [MB-1:0] mr_r  [0:SW];
  logic [SW-1:0] step;

  assign step = {{(SW-TB){1'b0}}, dt_r[DS]} +
                (random_offset_r ? {{(SW-NB){1'b0}}, dhr_r[DS]} : SW'(0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r[0] <= 1'b0;
    end else if (adv) begin
      mv_r[0] <= dv_r[DS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mh_r[0]  <= dh_r[DS];
      mst_r[0] <= step;
      msh_r[0] <= step;
      mr_r[0]  <= '0;
    end
  end

  for (genvar j = 0; j < SW; j++) begin : g_mod
    logic [MB:0] psh;
    logic [MB:0] psub;

    assign psh  = {mr_r[j], msh_r[j][SW-1]};
    assign psub = psh - {1'b0, period};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        mv_r[j+1] <= 1'b0;
      end else if (adv) begin
        mv_r[j+1] <= mv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        mh_r[j+1]  <= mh_r[j];
        mst_r[j+1] <= mst_r[j];
        msh_r[j+1] <= msh_r[j] << 1;
        mr_r[j+1]  <= (psh >= {1'b0, period}) ? psub[MB-1:0] : psh[MB-1:0];
      end
    end
  end

  // Final frame selection.
  logic [31:0] frame_sel;
  logic [MB-1:0] pp_rem;

  assign pp_rem = mr_r[SW];

  always_comb begin
    if (degenerate) begin
      frame_sel = 32'd0;
    end else begin
      case (anim_mode_r)
        MODE_ONCE: begin
          if (mst_r[SW] < SW'(n_sat)) begin
            frame_sel = 32'(mst_r[SW]);
          end else begin
            frame_sel = 32'(n_m1);
          end
        end
        MODE_PINGPONG: begin
          if (pp_rem < {1'b0, n_sat}) begin
            frame_sel = 32'(pp_rem);
          end else begin
            frame_sel = 32'(MB'(period - pp_rem));
          end
        end
        default: frame_sel = 32'(pp_rem);
      endcase
    end
  end

  logic [7:0]  out_frame_r;
  logic [31:0] out_hash_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= mv_r[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_frame_r <= frame_sel[7:0];
      out_hash_r  <= mh_r[SW];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_index   = out_frame_r;
  assign out_position_hash = out_hash_r;

  // An accepted beat always enters the first stage.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> h0_v_r)
    else $error("accepted beat did not enter the pipeline");

  // A degenerate animation always yields frame zero.
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && degenerate |-> out_frame_index == 8'd0)
    else $error("degenerate animation gave a nonzero frame");

  // In play-once mode the frame never passes the last frame.
  a_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !degenerate && anim_mode_r == MODE_ONCE |->
      32'(out_frame_index) <= 32'(n_m1))
    else $error("play-once frame beyond last frame");

  // A stall freezes every stage, so the last stage keeps its beat.
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(mv_r[SW]) && $stable(mh_r[SW]))
    else $error("pipeline moved during a stall");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

// Testbench for the tile animation frame selector.
// A directed table of beats is followed by random beats in several
// configuration phases. Every accepted input beat is run through a local
// predictor of the frame index and the position hash, and the expectation is
// queued. Every accepted output beat is compared against the oldest entry.
module testbench;
  import tafs_pkg::*;

  localparam int MAX_FRAMES = 256;
  localparam int LATENCY    = 69;
  localparam int LIMIT      = 400000;

  typedef struct packed {
    logic [30:0] time_ticks;
    logic [15:0] tile_x;
    logic [15:0] tile_y;
  } tile_beat_t;

  typedef struct packed {
    logic [7:0]  frame_index;
    logic [31:0] position_hash;
  } frame_beat_t;

  // One row of the directed table. When has_exp is set, the frame index is
  // also checked against the literal typed into the row.
  typedef struct packed {
    tile_beat_t  beat;
    logic        has_exp;
    logic [7:0]  exp_frame;
  } directed_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [30:0] in_time_ticks;
  logic signed [15:0] in_tile_x;
  logic signed [15:0] in_tile_y;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_frame_index;
  logic [31:0] out_position_hash;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // Local copy of the configuration registers, mirrored on every write.
  logic [8:0]  count_q;
  logic [15:0] duration_q;
  anim_mode_t  mode_q;
  logic        offset_q;

  frame_beat_t pending_frames[$];
  logic [7:0]  pinned_frames[$];
  logic        pinned_valid[$];
  int          error_count;
  int          cycle_count;
  bit          hold_receiver;
  int          long_hold_cycles;

  tile_animation_frame_select uut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [31:0] tile_hash(logic [15:0] x, logic [15:0] y);
    logic [31:0] h;
    h = ({{16{x[15]}}, x} * HASH_MUL_X) ^ ({{16{y[15]}}, y} * HASH_MUL_Y);
    h = h ^ (h >> 13);
    h = h * HASH_MIX;
    h = h ^ (h >> 15);
    return h;
  endfunction

  function automatic frame_beat_t predict_frame(tile_beat_t b);
    frame_beat_t r;
    logic [63:0] n;
    logic [63:0] step;
    logic [63:0] period;
    logic [63:0] p;
    logic [63:0] frame;
    r.position_hash = tile_hash(b.tile_x, b.tile_y);
    n = (count_q > MAX_FRAMES) ? 64'(MAX_FRAMES) : 64'(count_q);
    frame = '0;
    if (n > 1 && duration_q != 0) begin
      step = {33'd0, b.time_ticks} / duration_q;
      if (offset_q) step = step + ({32'd0, r.position_hash} % n);
      case (mode_q)
        MODE_ONCE: begin
          frame = (step < n) ? step : n - 1;
        end
        MODE_PINGPONG: begin
          period = 2 * (n - 1);
          p = step % period;
          frame = (p < n) ? p : period - p;
        end
        default: begin
          frame = step % n;
        end
      endcase
    end
    r.frame_index = frame[7:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
             cycle_count);
    error_count++;
  endtask

  // Drives one register write, then idles with the enable low so that back to
  // back writes never retime the enable within a single step.
  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_FRAME_COUNT:    count_q    = value[8:0];
      REG_FRAME_DURATION: duration_q = value;
      REG_ANIM_MODE:      mode_q     = anim_mode_t'(value[1:0]);
      REG_RANDOM_OFFSET:  offset_q   = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_animation(input logic [8:0] count, input logic [15:0] duration,
                               input anim_mode_t mode, input logic offset);
    write_reg(REG_FRAME_COUNT, {7'd0, count});
    write_reg(REG_FRAME_DURATION, duration);
    write_reg(REG_ANIM_MODE, {14'd0, mode});
    write_reg(REG_RANDOM_OFFSET, {15'd0, offset});
  endtask

  // Offers one beat after a random gap and waits for it to be taken.
  // The expectation is queued at the accepting edge. Valid stays high after
  // the accepting edge; the next gap or the caller drops it.
  task automatic send_beat(input tile_beat_t b, input logic has_exp,
                           input logic [7:0] exp_frame, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9));
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_time_ticks <= b.time_ticks;
    in_tile_x     <= b.tile_x;
    in_tile_y     <= b.tile_y;
    do @(posedge clk); while (!in_ready);
    pending_frames.insert(pending_frames.size(), predict_frame(b));
    pinned_valid.insert(pinned_valid.size(), has_exp);
    pinned_frames.insert(pinned_frames.size(), exp_frame);
  endtask

  // Waits until every queued result has come back, then lets the pipeline
  // drain fully so that a following register write sees it empty.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic tile_beat_t random_beat();
    tile_beat_t b;
    case ($urandom_range(0, 5))
      0: b.time_ticks = 31'($urandom_range(0, 300));
      1: b.time_ticks = 31'(32'h7fffffff - $urandom_range(0, 300));
      2: b.time_ticks = 31'($urandom_range(0, 100000));
      default: b.time_ticks = 31'($urandom);
    endcase
    b.tile_x = 16'($urandom);
    b.tile_y = 16'($urandom);
    return b;
  endfunction

  // Receiver: random stall per beat, plus an optional long hold-off that the
  // stimulus requests to back the pipeline up into its input.
  initial begin
    int wait_cycles;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_receiver) begin
        out_ready <= 1'b0;
        repeat (long_hold_cycles) @(posedge clk);
        hold_receiver = 1'b0;
      end
      wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
      if (wait_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Output checker: compares each accepted result beat with the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    frame_beat_t want;
    logic        pinned;
    logic [7:0]  pinned_frame;
    if (rst_n && out_valid && out_ready) begin
      if (pending_frames.size() == 0) begin
        report_mismatch("unexpected beat", {24'd0, out_frame_index}, 32'd0);
      end else begin
        want         = pending_frames.pop_front();
        pinned       = pinned_valid.pop_front();
        pinned_frame = pinned_frames.pop_front();
        if (out_frame_index !== want.frame_index)
          report_mismatch("frame_index", {24'd0, out_frame_index},
                          {24'd0, want.frame_index});
        if (pinned && out_frame_index !== pinned_frame)
          report_mismatch("frame_index vs table", {24'd0, out_frame_index},
                          {24'd0, pinned_frame});
        if (out_position_hash !== want.position_hash)
          report_mismatch("position_hash", out_position_hash, want.position_hash);
      end
    end
  end

  initial begin
    directed_row_t rows[$];
    cycle_count   = 0;
    error_count   = 0;
    hold_receiver = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_time_ticks = '0;
    in_tile_x     = '0;
    in_tile_y     = '0;
    cfg_we        = 1'b0;
    cfg_index     = REG_FRAME_COUNT;
    cfg_data      = '0;
    count_q       = 9'd1;
    duration_q    = 16'd1;
    mode_q        = MODE_LOOP;
    offset_q      = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset the count is one, so every frame is zero.
    rows = '{
      '{'{31'd0, 16'sh0000, 16'sh0000}, 1'b1, 8'd0},
      '{'{31'h7fffffff, 16'sh7fff, 16'sh8000}, 1'b1, 8'd0},
      '{'{31'd12345, 16'shffff, 16'sh0001}, 1'b1, 8'd0}
    };
    foreach (rows[i]) send_beat(rows[i].beat, rows[i].has_exp, rows[i].exp_frame, 0);
    drain_pipeline();

    // Loop over four frames, one tick each.
    set_animation(9'd4, 16'd1, MODE_LOOP, 1'b0);
    rows = '{
      '{'{31'd5, 16'sh8000, 16'sh7fff}, 1'b1, 8'd1},
      '{'{31'd7, 16'sh0000, 16'shffff}, 1'b1, 8'd3},
      '{'{31'h7fffffff, 16'sh1234, 16'sh4321}, 1'b1, 8'd3}
    };
    foreach (rows[i]) send_beat(rows[i].beat, rows[i].has_exp, rows[i].exp_frame, 0);
    drain_pipeline();

    // Play once over four frames: clamps at the last frame.
    set_animation(9'd4, 16'd1, MODE_ONCE, 1'b0);
    rows = '{
      '{'{31'd2, 16'sh0001, 16'sh0002}, 1'b1, 8'd2},
      '{'{31'd100, 16'sh0001, 16'sh0002}, 1'b1, 8'd3}
    };
    foreach (rows[i]) send_beat(rows[i].beat, rows[i].has_exp, rows[i].exp_frame, 0);
    drain_pipeline();

    // Ping-pong over four frames: period six, reflected index.
    set_animation(9'd4, 16'd1, MODE_PINGPONG, 1'b0);
    rows = '{
      '{'{31'd3, 16'sh0003, 16'sh0004}, 1'b1, 8'd3},
      '{'{31'd4, 16'sh0003, 16'sh0004}, 1'b1, 8'd2},
      '{'{31'd5, 16'sh0003, 16'sh0004}, 1'b1, 8'd1},
      '{'{31'd6, 16'sh0003, 16'sh0004}, 1'b1, 8'd0}
    };
    foreach (rows[i]) send_beat(rows[i].beat, rows[i].has_exp, rows[i].exp_frame, 0);
    drain_pipeline();

    // Zero duration forces frame zero; the spare mode code acts as loop.
    set_animation(9'd4, 16'd0, MODE_SPARE, 1'b1);
    send_beat('{31'd99, 16'sh0005, 16'sh0006}, 1'b1, 8'd0, 0);
    drain_pipeline();
    write_reg(REG_FRAME_DURATION, 16'd1);
    send_beat('{31'd6, 16'sh0005, 16'sh0006}, 1'b0, 8'd0, 0);
    drain_pipeline();

    // A count above the frame limit saturates; a count of zero yields zero.
    set_animation(9'd511, 16'hffff, MODE_LOOP, 1'b1);
    send_beat('{31'h7fffffff, 16'sh7fff, 16'sh7fff}, 1'b0, 8'd0, 0);
    send_beat('{31'd0, 16'sh8000, 16'sh8000}, 1'b0, 8'd0, 0);
    drain_pipeline();
    write_reg(REG_FRAME_COUNT, 16'd0);
    send_beat('{31'd1000, 16'sh0042, 16'sh0024}, 1'b1, 8'd0, 0);
    drain_pipeline();

    // Random phases, each under a fresh random configuration; the first few
    // pin the extremes of the count, duration and mode.
    for (int phase = 0; phase < 24; phase++) begin
      case (phase)
        0: set_animation(9'd256, 16'd1, MODE_PINGPONG, 1'b1);
        1: set_animation(9'd2, 16'hffff, MODE_ONCE, 1'b1);
        2: set_animation(9'd257, 16'd3, MODE_LOOP, 1'b0);
        3: set_animation(9'd2, 16'd1, MODE_PINGPONG, 1'b0);
        default: set_animation(9'($urandom_range(0, 511)),
                               ($urandom_range(0, 3) == 0) ?
                                 16'($urandom_range(0, 4)) :
                                 16'($urandom_range(0, 65535)),
                               anim_mode_t'($urandom_range(0, 3)),
                               1'($urandom_range(0, 1)));
      endcase
      // Once per run the receiver stops for a long while as the sender keeps
      // offering beats back to back, so the pipeline fills and stalls.
      if (phase == 5) begin
        long_hold_cycles = 300;
        hold_receiver    = 1'b1;
        for (int k = 0; k < 150; k++) send_beat(random_beat(), 1'b0, 8'd0, 1);
      end
      for (int k = 0; k < 75; k++) begin
        send_beat(random_beat(), 1'b0, 8'd0, 0);
        // Occasionally the sender waits for every result before going on.
        if ($urandom_range(0, 40) == 0) begin
          in_valid <= 1'b0;
          while (pending_frames.size() != 0) @(posedge clk);
        end
      end
      drain_pipeline();
    end

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
